>>> rtl/pdm_pkg.sv
// pdm_pkg: types, register codes and saturating helpers for the drift map.
// No dependencies; used by every module of the drift map core.

package pdm_pkg;

	localparam int DEF_FRAC_BITS = 40;
	localparam int FMUL_LAT      = 4;
	localparam int CFG_IDX_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_LENGTH = CFG_IDX_W'(1);

	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic {
		MODE_EXPANDED = 1'b0,
		MODE_EXACT    = 1'b1
	} drift_mode_t;

	typedef struct packed {
		logic        [31:0] particle_index;
		logic signed [63:0] x_in;
		logic signed [63:0] y_in;
		logic signed [63:0] px_in;
		logic signed [63:0] py_in;
		logic signed [63:0] sigma_in;
		logic signed [63:0] s_in;
		logic signed [63:0] delta_in;
		logic signed [63:0] psigma_in;
		logic signed [63:0] rpp_in;
		logic signed [63:0] rvv_in;
		logic signed [63:0] beta0_in;
	} in_item_t;

	typedef struct packed {
		logic        [31:0] particle_index_out;
		logic signed [63:0] x_out;
		logic signed [63:0] y_out;
		logic signed [63:0] sigma_out;
		logic signed [63:0] s_out;
		logic               invalid;
	} out_item_t;

	// root plus divide unit: digit-per-stage sqrt, bit-per-stage divide, one output reg
	function automatic int rd_lat(input int fb);
		return (64 + fb + 1) / 2 + 64 + fb + 1;
	endfunction

	// start transfer edge to done sampled high
	function automatic int pipe_lat(input int fb);
		return 2 * FMUL_LAT + 2 + rd_lat(fb) + 2;
	endfunction

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// sign applied to a magnitude; hi flags magnitude bits above 63
	function automatic logic [63:0] sat_mag(input logic neg, input logic hi,
			input logic [63:0] m);
		if (neg) begin
			if (hi || (m[63] && (|m[62:0]))) return S64_MIN;
			return 64'd0 - m;
		end
		if (hi || m[63]) return S64_MAX;
		return m;
	endfunction

endpackage

>>> rtl/pdm_fmul.sv
// pdm_fmul: pipelined signed fixed-point multiply, round half away, saturate.
// Depends on pdm_pkg. Registers magnitudes, partial products, sum, scaled result; one operand pair per cycle.

module pdm_fmul import pdm_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	localparam int RVW = 128 - FRAC_BITS;
	localparam logic [127:0] RND = 128'(1) << (FRAC_BITS - 1);

	logic          neg_s1, neg_s2, neg_s3;
	logic [63:0]   ma_s1, mb_s1;
	logic [63:0]   ll_s2, lh_s2, hl_s2, hh_s2;
	logic [127:0]  sum_s3;
	logic [RVW-1:0] rv;

	assign rv = sum_s3[127:FRAC_BITS];

	always_ff @(posedge clk) begin
		// magnitudes
		neg_s1 <= a[63] ^ b[63];
		ma_s1  <= a[63] ? (64'd0 - a) : a;
		mb_s1  <= b[63] ? (64'd0 - b) : b;
		// 32x32 partial products
		neg_s2 <= neg_s1;
		ll_s2  <= ma_s1[31:0]  * mb_s1[31:0];
		lh_s2  <= ma_s1[31:0]  * mb_s1[63:32];
		hl_s2  <= ma_s1[63:32] * mb_s1[31:0];
		hh_s2  <= ma_s1[63:32] * mb_s1[63:32];
		// sum plus rounding offset
		neg_s3 <= neg_s2;
		sum_s3 <= {hh_s2, 64'd0} + {32'd0, lh_s2, 32'd0} + {32'd0, hl_s2, 32'd0}
			+ {64'd0, ll_s2} + RND;
		// scale, sign, saturate
		p      <= sat_mag(neg_s3, |rv[RVW-1:64], rv[63:0]);
	end

endmodule

>>> rtl/pdm_root_div.sv
// pdm_root_div: L / floor(sqrt(arg * 2^FRAC_BITS)), quotient truncated and saturated.
// Depends on pdm_pkg. One root bit per stage, then one quotient bit per stage.

module pdm_root_div import pdm_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic [63:0] arg,
	input  logic [63:0] len,
	output logic [63:0] lpzi
);

	localparam int NB = 64 + FRAC_BITS;
	localparam int RW = (NB + 1) / 2;
	localparam int NW = 2 * RW;

	logic [NW-1:0] sq_n    [RW+1];
	logic [RW:0]   sq_rem  [RW+1];
	logic [RW-1:0] sq_root [RW+1];

	logic [RW-1:0] dv_rem [NB+1];
	logic [RW-1:0] dv_den [NB+1];
	logic [63:0]   dv_q   [NB+1];
	logic          dv_ovf [NB+1];

	logic [63:0]   len_mag;
	logic [NB-1:0] num;

	// user must keep the drift length static while items are in flight; this block does not enforce it
	assign len_mag = len[63] ? (64'd0 - len) : len;
	assign num     = {len_mag, {FRAC_BITS{1'b0}}};

	assign sq_n[0]    = NW'({arg, {FRAC_BITS{1'b0}}});
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_sq
		logic [RW+1:0] rsh, trial, diff;
		logic          ge;
		assign rsh   = {sq_rem[k][RW-1:0], sq_n[k][NW-1 -: 2]};
		assign trial = {sq_root[k], 2'b01};
		assign diff  = rsh - trial;
		assign ge    = rsh >= trial;
		always_ff @(posedge clk) begin
			sq_n[k+1]    <= sq_n[k] << 2;
			sq_rem[k+1]  <= ge ? diff[RW:0] : rsh[RW:0];
			sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
		end
	end

	assign dv_rem[0] = '0;
	assign dv_den[0] = sq_root[RW];
	assign dv_q[0]   = '0;
	assign dv_ovf[0] = 1'b0;

	for (genvar j = 0; j < NB; j++) begin : g_dv
		logic [RW:0] rsh, diff;
		logic        ge;
		assign rsh  = {dv_rem[j], num[NB-1-j]};
		assign diff = rsh - {1'b0, dv_den[j]};
		assign ge   = rsh >= {1'b0, dv_den[j]};
		always_ff @(posedge clk) begin
			dv_rem[j+1] <= ge ? diff[RW-1:0] : rsh[RW-1:0];
			dv_den[j+1] <= dv_den[j];
			dv_q[j+1]   <= {dv_q[j][62:0], ge};
			dv_ovf[j+1] <= dv_ovf[j] | dv_q[j][63];
		end
	end

	always_ff @(posedge clk) begin
		lpzi <= sat_mag(len[63], dv_ovf[NB], dv_q[NB]);
	end

endmodule

>>> rtl/particle_drift_map_core.sv
// particle_drift_map_core: streaming field-free drift of particle records.
// Depends on pdm_pkg, pdm_fmul, pdm_root_div.
//
// channel  | transfer marked by   | payload
// ---------+----------------------+--------------------------------
// item in  | start && !busy       | item   (in_item_t)
// result   | done (one cycle)     | result (out_item_t)
// config   | cfg_we               | cfg_index, cfg_data (no read-back)
//
// One item may be started every clock; busy is always low.
// done is registered from the valid bit at the final stage of the record line, whose
// depth is set by the divide chain: the root/divide unit holds (64+FRAC_BITS+1)/2 root
// stages and 64+FRAC_BITS quotient stages.
// Reset clears the valid bits and the registers (expanded mode, length zero).
// The receiver cannot stall, so the pipeline never holds.

module particle_drift_map_core import pdm_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             item,
	output logic                 done,
	output out_item_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int M      = FMUL_LAT;
	localparam int RD_LAT = rd_lat(FRAC_BITS);
	localparam int TL     = M + 2 + RD_LAT;       // lpzi ready
	localparam int F      = TL + M;               // final stage
	localparam int S      = F - 4 * M - 2;        // expanded map starts late, lands on F
	localparam int D_XY   = 2 * M + 2;
	localparam int D_C    = RD_LAT - M;
	localparam int D_INV  = RD_LAT + M;
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	drift_mode_t mode_q;
	logic [63:0] len_q;

	in_item_t    pipe_s [F+1];
	logic        pipe_v [F+1];

	// expanded map
	logic [63:0] e_spx, e_spy, e_sqx, e_sqy, e_xl, e_yl, e_rv, e_lv;
	logic [63:0] e_sq;
	logic [63:0] e_a_q, e_v_q;
	logic [63:0] xl_dly_q [D_XY];
	logic [63:0] yl_dly_q [D_XY];

	// exact map
	logic [63:0] opd_q, x_opd2, x_px2, x_py2, x_b2, x_bp, arg_q, c_q;
	logic [63:0] lpzi, x_xp, x_yp, x_cl;
	logic [63:0] c_dly_q [D_C];
	logic        inv_dly_q [D_INV];

	out_item_t   fin;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXPANDED;
			len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRIFT_MODE:   mode_q <= drift_mode_t'(cfg_data[0]);
				REG_DRIFT_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// record line and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= F; i++) pipe_v[i] <= 1'b0;
			done <= 1'b0;
		end else begin
			pipe_v[0] <= start && !busy;
			for (int i = 1; i <= F; i++) pipe_v[i] <= pipe_v[i-1];
			done <= pipe_v[F];
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0] <= item;
		for (int i = 1; i <= F; i++) pipe_s[i] <= pipe_s[i-1];
	end

	// ---- expanded map: spx, spy -> squares, L products -> rvv term -> L*v
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_spx (.clk, .a(pipe_s[S].px_in),
		.b(pipe_s[S].rpp_in), .p(e_spx));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_spy (.clk, .a(pipe_s[S].py_in),
		.b(pipe_s[S].rpp_in), .p(e_spy));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_sqx (.clk, .a(e_spx), .b(e_spx), .p(e_sqx));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_sqy (.clk, .a(e_spy), .b(e_spy), .p(e_sqy));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_xl  (.clk, .a(e_spx), .b(len_q), .p(e_xl));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_yl  (.clk, .a(e_spy), .b(len_q), .p(e_yl));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_rv  (.clk, .a(pipe_s[S+2*M+1].rvv_in),
		.b(e_a_q), .p(e_rv));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_e_lv  (.clk, .a(len_q), .b(e_v_q), .p(e_lv));

	assign e_sq = sat_add(e_sqx, e_sqy);

	always_ff @(posedge clk) begin
		// sum of squares is never negative: plain right shift halves it
		e_a_q <= sat_add(ONE, {1'b0, e_sq[63:1]});
		e_v_q <= sat_sub(ONE, e_rv);
		xl_dly_q[0] <= e_xl;
		yl_dly_q[0] <= e_yl;
		for (int i = 1; i < D_XY; i++) begin
			xl_dly_q[i] <= xl_dly_q[i-1];
			yl_dly_q[i] <= yl_dly_q[i-1];
		end
	end

	// ---- exact map: root argument -> sqrt/divide -> momentum products
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_opd2 (.clk, .a(opd_q), .b(opd_q), .p(x_opd2));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_px2  (.clk, .a(pipe_s[1].px_in),
		.b(pipe_s[1].px_in), .p(x_px2));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_py2  (.clk, .a(pipe_s[1].py_in),
		.b(pipe_s[1].py_in), .p(x_py2));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_b2   (.clk, .a(pipe_s[1].beta0_in),
		.b(pipe_s[1].beta0_in), .p(x_b2));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_bp   (.clk, .a(x_b2),
		.b(pipe_s[M+1].psigma_in), .p(x_bp));

	pdm_root_div #(.FRAC_BITS(FRAC_BITS)) u_root_div (.clk, .arg(arg_q), .len(len_q),
		.lpzi(lpzi));

	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_xp (.clk, .a(pipe_s[TL].px_in), .b(lpzi),
		.p(x_xp));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_yp (.clk, .a(pipe_s[TL].py_in), .b(lpzi),
		.p(x_yp));
	pdm_fmul #(.FRAC_BITS(FRAC_BITS)) u_x_cl (.clk, .a(c_dly_q[D_C-1]), .b(lpzi),
		.p(x_cl));

	always_ff @(posedge clk) begin
		opd_q <= sat_add(ONE, pipe_s[0].delta_in);
		arg_q <= sat_sub(sat_sub(x_opd2, x_px2), x_py2);
		c_q   <= sat_add(x_bp, ONE);
		c_dly_q[0] <= c_q;
		for (int i = 1; i < D_C; i++) c_dly_q[i] <= c_dly_q[i-1];
		// root argument not positive: pass through at the end
		inv_dly_q[0] <= arg_q[63] || (arg_q == '0);
		for (int i = 1; i < D_INV; i++) inv_dly_q[i] <= inv_dly_q[i-1];
	end

	// ---- final stage
	always_comb begin
		fin.particle_index_out = pipe_s[F].particle_index;
		fin.x_out     = pipe_s[F].x_in;
		fin.y_out     = pipe_s[F].y_in;
		fin.sigma_out = pipe_s[F].sigma_in;
		fin.s_out     = pipe_s[F].s_in;
		fin.invalid   = 1'b0;
		unique case (mode_q)
			MODE_EXPANDED: begin
				fin.x_out     = sat_add(pipe_s[F].x_in, xl_dly_q[D_XY-1]);
				fin.y_out     = sat_add(pipe_s[F].y_in, yl_dly_q[D_XY-1]);
				fin.sigma_out = sat_add(pipe_s[F].sigma_in, e_lv);
				fin.s_out     = sat_add(pipe_s[F].s_in, len_q);
			end
			MODE_EXACT: begin
				if (inv_dly_q[D_INV-1]) begin
					fin.invalid = 1'b1;
				end else begin
					fin.x_out     = sat_add(pipe_s[F].x_in, x_xp);
					fin.y_out     = sat_add(pipe_s[F].y_in, x_yp);
					fin.sigma_out = sat_add(pipe_s[F].sigma_in, sat_sub(len_q, x_cl));
					fin.s_out     = sat_add(pipe_s[F].s_in, len_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		result <= fin;
	end

endmodule

>>> rtl/pdm_checker.sv
// pdm_checker: port-level checks of the drift map core, bound to the top level.
// Depends on pdm_pkg and particle_drift_map_core.

module pdm_checker import pdm_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input in_item_t             item,
	input logic                 done,
	input out_item_t            result,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [63:0]          cfg_data
);

	localparam int LAT = pipe_lat(FRAC_BITS);

	drift_mode_t mode_q;
	logic [63:0] len_q;

	// shadow of the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXPANDED;
			len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRIFT_MODE:   mode_q <= drift_mode_t'(cfg_data[0]);
				REG_DRIFT_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("start transfer without result");

	a_done_caused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without start transfer");

	a_s_update: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.invalid |-> result.s_out == sat_add($past(item.s_in, LAT), len_q))
		else $error("s_out does not advance by the drift length");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.invalid |-> result.x_out == $past(item.x_in, LAT)
			&& result.s_out == $past(item.s_in, LAT))
		else $error("invalid particle was not passed through");

	a_exp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done && mode_q == MODE_EXPANDED |-> !result.invalid)
		else $error("invalid flag in expanded mode");

endmodule

bind particle_drift_map_core pdm_checker #(.FRAC_BITS(FRAC_BITS)) u_pdm_checker (.*);

>>> bench/tb_particle_drift_map_core.sv
// tb_particle_drift_map_core: self-checking bench for the particle drift map core.
// Depends on pdm_pkg and particle_drift_map_core; predicts each drifted record
// in fixed point and checks every result against the oldest pending expectation.

module tb_particle_drift_map_core;
	import pdm_pkg::*;

	localparam int          FB   = DEF_FRAC_BITS;
	localparam logic [63:0] ONE  = 64'd1 << FB;
	localparam int          LAT  = pipe_lat(DEF_FRAC_BITS);
	// indexes past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOP   = CFG_IDX_W'(15);

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	in_item_t             item      = '0;
	logic                 done;
	out_item_t            result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	particle_drift_map_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// bench copy of the registers
	drift_mode_t mode_cfg = MODE_EXPANDED;
	logic [63:0] len_cfg  = '0;

	in_item_t  pend_q[$];    // records waiting for their start transfer
	out_item_t drifted_q[$]; // predicted drift results, oldest first
	int        idle_pct = 0;
	int        err_cnt  = 0;

	// ---------------- fixed point arithmetic ----------------
	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	// signs a 128-bit magnitude and clamps it to the 64-bit range
	function automatic logic [63:0] clamp_signed(input logic neg, input logic [127:0] m);
		if (neg) begin
			if (m > 128'(S64_MIN)) return S64_MIN;
			return 64'd0 - m[63:0];
		end
		if (m > 128'(S64_MAX)) return S64_MAX;
		return m[63:0];
	endfunction

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		logic [63:0]  ma, mb;
		ma = a[63] ? 64'd0 - a : a;
		mb = b[63] ? 64'd0 - b : b;
		p  = {64'd0, ma} * {64'd0, mb};
		p  = (p + (128'd1 << (FB - 1))) >> FB; // round half away from zero
		return clamp_signed(a[63] ^ b[63], p);
	endfunction

	function automatic logic [63:0] qroot(input logic [63:0] arg);
		logic [127:0] n, c;
		logic [63:0]  r;
		n = {64'd0, arg} << FB;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = {64'd0, r | (64'd1 << b)};
			if (c * c <= n) r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] qdiv(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] m;
		m = {64'd0, num[63] ? 64'd0 - num : num} << FB;
		return clamp_signed(num[63], m / {64'd0, den});
	endfunction

	// ---------------- drift predictor ----------------
	function automatic out_item_t drift_particle(input in_item_t p);
		out_item_t   o;
		logic [63:0] spx, spy, sq, v, opd, arg, lpzi, lbzi;
		o.particle_index_out = p.particle_index;
		o.x_out = p.x_in; o.y_out = p.y_in;
		o.sigma_out = p.sigma_in; o.s_out = p.s_in;
		o.invalid = 1'b0;
		if (mode_cfg == MODE_EXPANDED) begin
			spx = qmul(p.px_in, p.rpp_in);
			spy = qmul(p.py_in, p.rpp_in);
			sq  = add_sat(qmul(spx, spx), qmul(spy, spy));
			v   = sub_sat(ONE, qmul(p.rvv_in, add_sat(ONE, sq >> 1)));
			o.x_out     = add_sat(p.x_in, qmul(spx, len_cfg));
			o.y_out     = add_sat(p.y_in, qmul(spy, len_cfg));
			o.sigma_out = add_sat(p.sigma_in, qmul(len_cfg, v));
			o.s_out     = add_sat(p.s_in, len_cfg);
		end else begin
			opd = add_sat(ONE, p.delta_in);
			arg = sub_sat(sub_sat(qmul(opd, opd), qmul(p.px_in, p.px_in)),
				qmul(p.py_in, p.py_in));
			if ($signed(arg) <= 0) begin
				// no real longitudinal momentum: record passes through
				o.invalid = 1'b1;
			end else begin
				lpzi = qdiv(len_cfg, qroot(arg));
				lbzi = qmul(add_sat(qmul(qmul(p.beta0_in, p.beta0_in), p.psigma_in), ONE),
					lpzi);
				o.x_out     = add_sat(p.x_in, qmul(p.px_in, lpzi));
				o.y_out     = add_sat(p.y_in, qmul(p.py_in, lpzi));
				o.sigma_out = add_sat(p.sigma_in, sub_sat(len_cfg, lbzi));
				o.s_out     = add_sat(p.s_in, len_cfg);
			end
		end
		return o;
	endfunction

	// ---------------- driver ----------------
	// pops a record on its start transfer, then offers the next one unless idling
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				drifted_q.push_back(drift_particle(item));
				void'(pend_q.pop_front());
			end
			if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item  <= pend_q[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_cnt++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (drifted_q.size() == 0) begin
				report_mismatch("unexpected result", result.x_out, '0);
			end else begin
				want = drifted_q.pop_front();
				if (result.particle_index_out !== want.particle_index_out)
					report_mismatch("index", 64'(result.particle_index_out),
						64'(want.particle_index_out));
				if (result.x_out !== want.x_out)
					report_mismatch("x", result.x_out, want.x_out);
				if (result.y_out !== want.y_out)
					report_mismatch("y", result.y_out, want.y_out);
				if (result.sigma_out !== want.sigma_out)
					report_mismatch("sigma", result.sigma_out, want.sigma_out);
				if (result.s_out !== want.s_out)
					report_mismatch("s", result.s_out, want.s_out);
				if (result.invalid !== want.invalid)
					report_mismatch("invalid", 64'(result.invalid), 64'(want.invalid));
			end
		end
	end

	// ---------------- stimulus helpers ----------------
	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	// signed random of about 'bits' significant bits
	function automatic logic [63:0] rnd_near(input int bits);
		return $signed(rnd64()) >>> (64 - bits);
	endfunction

	function automatic in_item_t make_particle();
		in_item_t p;
		int       kind;
		kind = $urandom_range(99);
		p.particle_index = $urandom;
		if (kind < 15) begin
			// raw noise over the whole field range
			{p.x_in, p.y_in, p.px_in, p.py_in, p.sigma_in, p.s_in} =
				{rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
			{p.delta_in, p.psigma_in, p.rpp_in, p.rvv_in, p.beta0_in} =
				{rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
		end else begin
			// physical record: small offsets and momenta, rpp and rvv near one
			p.x_in      = rnd_near(43);
			p.y_in      = rnd_near(43);
			p.px_in     = rnd_near(34);
			p.py_in     = rnd_near(34);
			p.sigma_in  = rnd_near(40);
			p.s_in      = rnd_near(50);
			p.delta_in  = rnd_near(36);
			p.psigma_in = rnd_near(36);
			p.rpp_in    = ONE - p.delta_in;
			p.rvv_in    = ONE + rnd_near(30);
			p.beta0_in  = {24'd0, 40'($urandom_range(0, 32'hFFFF_FFFF)) << 8};
			if (kind < 30) begin
				// momenta near the edge of the root argument going negative
				p.px_in = (ONE >> 1) + rnd_near(36);
				p.py_in = (ONE - (ONE >> 3)) + rnd_near(36);
			end
		end
		return p;
	endfunction

	task automatic add_directed();
		in_item_t p;
		p = '0;                                        // all zero
		pend_q.push_back(p);
		p = {32'hFFFF_FFFF, {11{S64_MAX}}};            // every field at maximum
		pend_q.push_back(p);
		p = {32'h0, {11{S64_MIN}}};                    // every field at minimum
		pend_q.push_back(p);
		p = '0; p.rpp_in = ONE; p.rvv_in = ONE; p.px_in = ONE >> 4; p.py_in = 64'd0 - (ONE >> 5);
		p.x_in = ONE; p.particle_index = 32'h1234_5678;
		pend_q.push_back(p);                           // plain paraxial record
		p.delta_in = 64'd0 - ONE;                      // 1+delta zero, root argument negative
		pend_q.push_back(p);
		p = '0; p.px_in = ONE;                         // px equals 1+delta
		pend_q.push_back(p);
		p.px_in = ONE + 64'd1;                         // argument just negative
		pend_q.push_back(p);
		p = '0; p.px_in = S64_MAX; p.rpp_in = S64_MAX; // saturated scaled momentum
		p.rvv_in = S64_MIN;
		pend_q.push_back(p);
		p = '0; p.delta_in = S64_MAX; p.beta0_in = ONE; p.psigma_in = S64_MIN;
		pend_q.push_back(p);                           // huge 1+delta, saturated psigma
		p = '0; p.x_in = S64_MAX; p.y_in = S64_MIN; p.s_in = S64_MAX;
		p.sigma_in = S64_MIN; p.px_in = ONE >> 2; p.py_in = 64'd0 - (ONE >> 2);
		p.rpp_in = ONE; p.rvv_in = ONE; p.beta0_in = ONE;
		pend_q.push_back(p);                           // sums pinned at the rails
		p = '0; p.delta_in = 64'd1 - ONE;              // root argument rounds to zero
		pend_q.push_back(p);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == REG_DRIFT_MODE)
			mode_cfg = drift_mode_t'(data[0]);
		else if (idx == REG_DRIFT_LENGTH)
			len_cfg = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// block idle: nothing waiting, nothing offered, nothing in flight
	task automatic drain();
		do @(negedge clk);
		while (pend_q.size() != 0 || start || drifted_q.size() != 0);
	endtask

	// ---------------- sequence ----------------
	initial begin
		logic [63:0] lens[9];
		lens = '{64'd0, ONE, ONE * 3, S64_MAX, S64_MIN, 64'd0, 64'd0, S64_MIN, ONE >> 3};
		lens[5] = rnd_near(45);
		lens[6] = rnd64();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			// mode bit carries random upper bits, which the block drops
			write_reg(REG_DRIFT_MODE, {rnd64() & ~64'd1} | 64'(ph[0]));
			write_reg(REG_DRIFT_LENGTH, lens[ph]);
			write_reg(ph[0] ? REG_SPARE : REG_TOP, rnd64());
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 83;
				2: idle_pct = 23;
				default: idle_pct = $urandom_range(0, 60);
			endcase
			if (ph < 2) add_directed();
			for (int i = 0; i < 72; i++) pend_q.push_back(make_particle());
		end
		drain();
		repeat (LAT + 20) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_particle_drift_map_core: done, clean");
		else
			$display("tb_particle_drift_map_core: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_particle_drift_map_core: done, errors");
		$finish;
	end

endmodule
